// File: hdl/blmin_pkg.sv
// Shared types and codes for the bounded record list with lowest-price search.
`timescale 1ns / 1ps
`default_nettype none

package blmin_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SWAP   = 3'd2;
    localparam logic [2:0] REQ_LOWEST = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Status codes returned with every result.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_EMPTY   = 3'd2;
    localparam logic [2:0] STS_BADPOS  = 3'd3;
    localparam logic [2:0] STS_TOOMANY = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_code;
        logic signed [31:0] item_price;
        logic signed [31:0] item_quantity;
        logic [7:0]         count_to_remove;
        logic [7:0]         pos_a;
        logic [7:0]         pos_b;
        logic [7:0]         read_position;
    } blmin_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         found_position;
        logic signed [31:0] entry_code;
        logic signed [31:0] entry_price;
        logic signed [31:0] entry_quantity;
        logic [7:0]         list_count;
        logic               list_full;
    } blmin_resp_t;

    // One stored record as it sits in a memory word.
    typedef struct packed {
        logic signed [31:0] code;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
    } blmin_rec_t;

    // Control from the sequencer to the minimum tracker.
    typedef struct packed {
        logic clear;
        logic sample;
    } blmin_scan_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWAP_B,
        ST_SWAP_WR_A,
        ST_SWAP_WR_B,
        ST_SCAN,
        ST_SCAN_END,
        ST_READ_WAIT,
        ST_DONE
    } blmin_state_t;

endpackage

`default_nettype wire

// File: hdl/blmin_scan.sv
// Running minimum tracker for the lowest-price search.
`timescale 1ns / 1ps
`default_nettype none

module blmin_scan #(
    parameter int ADDR_W = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire blmin_pkg::blmin_scan_ctl_t ctl,
    input  wire logic [ADDR_W-1:0]          sample_index,
    input  wire blmin_pkg::blmin_rec_t      sample_rec,
    output logic [ADDR_W-1:0]               best_index,
    output blmin_pkg::blmin_rec_t           best_rec
);
    import blmin_pkg::*;

    logic              have_reg;
    logic [ADDR_W-1:0] best_index_reg;
    blmin_rec_t        best_rec_reg;
    logic              take;

    // Strictly lower price only, so the earliest of equal prices is kept.
    assign take = !have_reg || ($signed(sample_rec.price) < $signed(best_rec_reg.price));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            have_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sample && !ctl.clear && take)
        begin
            best_index_reg <= sample_index;
            best_rec_reg   <= sample_rec;
        end
    end

    assign best_index = best_index_reg;
    assign best_rec   = best_rec_reg;

endmodule

`default_nettype wire

// File: hdl/bounded_list_with_min_search.sv
// Top level of the bounded record list with lowest-price search.
// Sequence from request transfer to result register: append, remove and rejected
// requests decode then finish; read adds a read wait, swap two reads and two writes,
// find-lowest a scan with one memory read per record and a scan end. One request is
// handled at a time; the output register lets the next request in while a result waits.
// Reset (rst_n, asynchronous, active low) empties the list; memory contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_with_min_search #(
    parameter int CAPACITY = 128
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire blmin_pkg::blmin_req_t req,
    output logic                       resp_valid,
    input  wire logic                  resp_stall,
    output blmin_pkg::blmin_resp_t     resp
);
    import blmin_pkg::*;

    // Address width of the record memory, width of the record count, and a
    // common width wide enough for both the count and the 8-bit positions.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    // The records live in one synchronous memory: one write port and one read
    // port whose data is registered. Each word holds code, price and quantity.
    blmin_rec_t mem [CAPACITY];

    blmin_state_t state_reg, state_next;
    blmin_req_t   req_reg;
    logic [CW-1:0] count_reg;
    blmin_rec_t   rd_data_reg;
    blmin_rec_t   tmp_reg;
    logic [2:0]   res_status_reg;
    logic [CW-1:0] res_found_reg;
    blmin_rec_t   res_rec_reg;
    logic [CW-1:0] scan_idx_reg;
    logic         resp_valid_reg;
    blmin_resp_t  resp_reg;

    // Memory port controls, driven by the output decode of the sequencer.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    blmin_rec_t    wr_data;
    blmin_scan_ctl_t scan_ctl;
    logic [AW-1:0] scan_sample_idx;
    logic [AW-1:0] best_index;
    blmin_rec_t    best_rec;

    // Request checks, all made against the count held before the request.
    logic [PW-1:0] count_ext;
    logic [PW-1:0] pa_ext;
    logic [PW-1:0] pb_ext;
    logic [PW-1:0] pr_ext;
    logic [PW-1:0] found_ext;
    logic          pa_ok;
    logic          pb_ok;
    logic          pr_ok;
    logic          rem_ok;
    logic          list_is_full;
    logic          list_is_empty;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_r;
    logic          scan_more;
    logic          resp_free;

    assign count_ext     = PW'(count_reg);
    assign pa_ext        = PW'(req_reg.pos_a);
    assign pb_ext        = PW'(req_reg.pos_b);
    assign pr_ext        = PW'(req_reg.read_position);
    assign found_ext     = PW'(res_found_reg);
    assign pa_ok         = (pa_ext != '0) && (pa_ext <= count_ext);
    assign pb_ok         = (pb_ext != '0) && (pb_ext <= count_ext);
    assign pr_ok         = (pr_ext != '0) && (pr_ext <= count_ext);
    assign rem_ok        = PW'(req_reg.count_to_remove) <= count_ext;
    assign list_is_full  = (count_reg == CW'(CAPACITY));
    assign list_is_empty = (count_reg == '0);
    assign addr_a        = AW'(pa_ext - PW'(1));
    assign addr_b        = AW'(pb_ext - PW'(1));
    assign addr_r        = AW'(pr_ext - PW'(1));
    // During the scan, scan_idx_reg is the next record to fetch; the record
    // arriving from the memory is the one before it.
    assign scan_more       = (scan_idx_reg != count_reg);
    assign scan_sample_idx = AW'(scan_idx_reg - CW'(1));
    // The output register can take a new result when it is empty or its
    // current result is being transferred in this cycle.
    assign resp_free = !resp_valid_reg || !resp_stall;

    // Next state of the request sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (req_reg.req_type)
                    REQ_SWAP:   state_next = (pa_ok && pb_ok) ? ST_SWAP_B : ST_DONE;
                    REQ_LOWEST: state_next = list_is_empty ? ST_DONE : ST_SCAN;
                    REQ_READ:   state_next = pr_ok ? ST_READ_WAIT : ST_DONE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_SWAP_B:    state_next = ST_SWAP_WR_A;
            ST_SWAP_WR_A: state_next = ST_SWAP_WR_B;
            ST_SWAP_WR_B: state_next = ST_DONE;
            ST_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:  state_next = ST_DONE;
            ST_READ_WAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (resp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory and scan controls for each state. A swap reads position a, then
    // position b, then writes b's record at a and the saved copy of a at b.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = rd_data_reg;
        scan_ctl = '0;
        case (state_reg)
            ST_DECODE:
            begin
                case (req_reg.req_type)
                    REQ_APPEND:
                    begin
                        wr_en   = !list_is_full;
                        wr_addr = AW'(count_reg);
                        wr_data = '{code: req_reg.item_code, price: req_reg.item_price,
                                    quantity: req_reg.item_quantity};
                    end
                    REQ_SWAP:
                    begin
                        rd_en   = pa_ok && pb_ok;
                        rd_addr = addr_a;
                    end
                    REQ_LOWEST:
                    begin
                        rd_en          = !list_is_empty;
                        rd_addr        = '0;
                        scan_ctl.clear = 1'b1;
                    end
                    REQ_READ:
                    begin
                        rd_en   = pr_ok;
                        rd_addr = addr_r;
                    end
                    default:
                    begin
                        rd_en = 1'b0;
                    end
                endcase
            end
            ST_SWAP_B:
            begin
                rd_en   = 1'b1;
                rd_addr = addr_b;
            end
            ST_SWAP_WR_A:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_a;
                wr_data = rd_data_reg;
            end
            ST_SWAP_WR_B:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = tmp_reg;
            end
            ST_SCAN:
            begin
                scan_ctl.sample = 1'b1;
                rd_en           = scan_more;
                rd_addr         = AW'(scan_idx_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Record memory. Writes of one request always finish before the next
    // request reads, so no forwarding path is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    blmin_scan #(
        .ADDR_W(AW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .sample_index (scan_sample_idx),
        .sample_rec   (rd_data_reg),
        .best_index   (best_index),
        .best_rec     (best_rec)
    );

    // Control state: sequencer, record count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DECODE)
            begin
                if ((req_reg.req_type == REQ_APPEND) && !list_is_full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if ((req_reg.req_type == REQ_REMOVE) && rem_ok)
                begin
                    count_reg <= count_reg - CW'(req_reg.count_to_remove);
                end
            end
            if ((state_reg == ST_DONE) && resp_free)
            begin
                resp_valid_reg <= 1'b1;
            end
            else if (!resp_stall)
            begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers. A result with no record carries zero position and fields.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_reg <= req;
                end
            end
            ST_DECODE:
            begin
                res_status_reg <= STS_OK;
                res_found_reg  <= '0;
                res_rec_reg    <= '0;
                scan_idx_reg   <= CW'(1);
                case (req_reg.req_type)
                    REQ_APPEND:
                    begin
                        if (list_is_full)
                        begin
                            res_status_reg <= STS_FULL;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!rem_ok)
                        begin
                            res_status_reg <= STS_TOOMANY;
                        end
                    end
                    REQ_SWAP:
                    begin
                        if (!(pa_ok && pb_ok))
                        begin
                            res_status_reg <= STS_BADPOS;
                        end
                    end
                    REQ_LOWEST:
                    begin
                        if (list_is_empty)
                        begin
                            res_status_reg <= STS_EMPTY;
                        end
                    end
                    REQ_READ:
                    begin
                        if (pr_ok)
                        begin
                            res_found_reg <= CW'(pr_ext);
                        end
                        else
                        begin
                            res_status_reg <= STS_BADPOS;
                        end
                    end
                    default:
                    begin
                        res_status_reg <= STS_OK;
                    end
                endcase
            end
            ST_SWAP_B:
            begin
                tmp_reg <= rd_data_reg;
            end
            ST_SCAN:
            begin
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end
            ST_SCAN_END:
            begin
                res_found_reg <= CW'(best_index) + CW'(1);
                res_rec_reg   <= best_rec;
            end
            ST_READ_WAIT:
            begin
                res_rec_reg <= rd_data_reg;
            end
            ST_DONE:
            begin
                if (resp_free)
                begin
                    resp_reg.status         <= res_status_reg;
                    resp_reg.found_position <= found_ext[7:0];
                    resp_reg.entry_code     <= res_rec_reg.code;
                    resp_reg.entry_price    <= res_rec_reg.price;
                    resp_reg.entry_quantity <= res_rec_reg.quantity;
                    resp_reg.list_count     <= count_ext[7:0];
                    resp_reg.list_full      <= list_is_full;
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    // A new request transfer is taken only while the sequencer is free.
    assign req_stall  = (state_reg != ST_IDLE);
    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    // The record count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count above capacity");

    // The scan only reads; no record moves while the minimum is searched.
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("memory write during lowest-price scan");

    // An accepted request is decoded in the following cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded");

    // A result appears only after the sequencer has finished a request.
    a_resp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

endmodule

`default_nettype wire
